// ===== rtl/core/mhd_pkg.sv =====
// Shared types, constants and the arctangent table of the magnetometer heading unit.
// Depends on nothing; every rtl/core file uses it by scoped names.
`default_nettype none
package mhd_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int XW = 28;   // CORDIC x/y datapath, scaled by 256
    localparam int ZW = 25;   // angle, 1/256 of a hundredth of a degree
    localparam int SW = 27;   // angle plus alignment
    localparam int HW = 19;   // rounded hundredths before wrap

    localparam int FRAC_BITS     = 8;
    localparam int QUARTER_UNITS = 2304000;
    localparam int FULL_TURN     = 36000;

    localparam logic [1:0] REG_X_BIAS    = 2'd0;
    localparam logic [1:0] REG_Y_BIAS    = 2'd1;
    localparam logic [1:0] REG_ALIGNMENT = 2'd2;

    typedef struct packed {
        logic signed [XW-1:0] cx;
        logic signed [XW-1:0] cy;
        logic signed [ZW-1:0] ang;
        logic                 zero;
        logic [15:0]          raw_x;
        logic [15:0]          raw_y;
        logic [15:0]          raw_z;
        logic [31:0]          stamp;
    } item_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    function automatic int atan_unit(input int i);
        int r;
        unique case (i)
            0:  r = 1152000;
            1:  r = 680065;
            2:  r = 359328;
            3:  r = 182400;
            4:  r = 91554;
            5:  r = 45822;
            6:  r = 22916;
            7:  r = 11459;
            8:  r = 5730;
            9:  r = 2865;
            10: r = 1432;
            11: r = 716;
            12: r = 358;
            13: r = 179;
            14: r = 90;
            15: r = 45;
            16: r = 22;
            17: r = 11;
            18: r = 6;
            19: r = 3;
            20: r = 1;
            21: r = 1;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/magnetometer_heading_unit.sv =====
// Top level of the magnetometer heading unit: configuration registers, front, queue, back end.
// Depends on mhd_pkg, mhd_front, mhd_queue and mhd_back.
`default_nettype none
// Takes one magnetometer sample (three little-endian byte pairs and a timestamp) per
// transaction and returns one transaction with the assembled X, Y, Z readings, the
// timestamp and the compass heading in hundredths of a degree (0..35999). The heading is
// atan2 of the offset-corrected Y and X, plus the alignment angle, rounded and wrapped.
// One sample is accepted every cycle while the output is not stalled. From input to output
// a sample passes one front register, the queue, one CORDIC stage per iteration, one
// rounding stage and the output register. The QUEUE_DEPTH-entry queue keeps the input
// open while the output is stalled, until the queue fills up.
module magnetometer_heading_unit #(
    parameter int CORDIC_STEPS = mhd_pkg::CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH  = mhd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         x_low_byte,
    input  wire logic [7:0]         x_high_byte,
    input  wire logic [7:0]         y_low_byte,
    input  wire logic [7:0]         y_high_byte,
    input  wire logic [7:0]         z_low_byte,
    input  wire logic [7:0]         z_high_byte,
    input  wire logic [31:0]        time_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      field_x,
    output logic signed [15:0]      field_y,
    output logic signed [15:0]      field_z,
    output logic [15:0]             heading,
    output logic [31:0]             time_out
);

    logic signed [15:0] x_bias_reg;
    logic signed [15:0] y_bias_reg;
    logic [15:0]        alignment_reg;

    logic               q_push;
    logic               q_pop;
    mhd_pkg::item_t     q_in_item;
    mhd_pkg::item_t     q_head_item;
    mhd_pkg::q_stat_t   q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_bias_reg    <= -16'sd370;
            y_bias_reg    <= 16'sd40;
            alignment_reg <= 16'd4500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mhd_pkg::REG_X_BIAS:    x_bias_reg    <= cfg_data;
                mhd_pkg::REG_Y_BIAS:    y_bias_reg    <= cfg_data;
                mhd_pkg::REG_ALIGNMENT: alignment_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    mhd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_low_byte  (x_low_byte),
        .x_high_byte (x_high_byte),
        .y_low_byte  (y_low_byte),
        .y_high_byte (y_high_byte),
        .z_low_byte  (z_low_byte),
        .z_high_byte (z_high_byte),
        .time_in     (time_in),
        .x_bias      (x_bias_reg),
        .y_bias      (y_bias_reg),
        .q_stat      (q_stat),
        .push        (q_push),
        .push_item   (q_in_item)
    );

    mhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head_item (q_head_item),
        .q_stat    (q_stat)
    );

    mhd_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_item       (q_head_item),
        .q_stat          (q_stat),
        .pop             (q_pop),
        .alignment_angle (alignment_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .field_x         (field_x),
        .field_y         (field_y),
        .field_z         (field_z),
        .heading         (heading),
        .time_out        (time_out)
    );

`ifndef ASSERT_OFF
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading < 16'(mhd_pkg::FULL_TURN)))
        else $error("heading outside one turn");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_stat.full)
        else $error("input stalled while queue has room");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !q_pop)
        else $error("queue popped while output stalled");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mhd_front.sv =====
// Front stage: accept a sample, assemble readings, remove X and Y offsets, pre-rotate into x >= 0.
// Depends on mhd_pkg.
`default_nettype none
module mhd_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            x_low_byte,
    input  wire logic [7:0]            x_high_byte,
    input  wire logic [7:0]            y_low_byte,
    input  wire logic [7:0]            y_high_byte,
    input  wire logic [7:0]            z_low_byte,
    input  wire logic [7:0]            z_high_byte,
    input  wire logic [31:0]           time_in,
    input  wire logic signed [15:0]    x_bias,
    input  wire logic signed [15:0]    y_bias,
    input  wire mhd_pkg::q_stat_t      q_stat,
    output logic                       push,
    output mhd_pkg::item_t             push_item
);

    logic            front_valid_reg;
    logic            front_valid_next;
    mhd_pkg::item_t  front_item_reg;
    mhd_pkg::item_t  item_next;
    logic            advance;
    logic            take;

    logic [15:0]                  raw_x;
    logic [15:0]                  raw_y;
    logic signed [16:0]           xc;
    logic signed [16:0]           yc;
    logic signed [mhd_pkg::XW-1:0] xs;
    logic signed [mhd_pkg::XW-1:0] ys;

    assign push     = front_valid_reg && !q_stat.full;
    assign advance  = !front_valid_reg || !q_stat.full;
    assign in_stall = !advance;
    assign take     = in_valid && advance;

    assign raw_x = {x_high_byte, x_low_byte};
    assign raw_y = {y_high_byte, y_low_byte};
    assign xc    = $signed({raw_x[15], raw_x}) - $signed({x_bias[15], x_bias});
    assign yc    = $signed({raw_y[15], raw_y}) - $signed({y_bias[15], y_bias});
    assign xs    = mhd_pkg::XW'($signed({xc, 8'b0}));
    assign ys    = mhd_pkg::XW'($signed({yc, 8'b0}));

    always_comb
    begin
        item_next.raw_x = raw_x;
        item_next.raw_y = raw_y;
        item_next.raw_z = {z_high_byte, z_low_byte};
        item_next.stamp = time_in;
        item_next.zero  = (xc == '0) && (yc == '0);
        priority if (xs < 0 && ys >= 0)
        begin
            item_next.cx  = ys;
            item_next.cy  = -xs;
            item_next.ang = mhd_pkg::ZW'(mhd_pkg::QUARTER_UNITS);
        end
        else if (xs < 0)
        begin
            item_next.cx  = -ys;
            item_next.cy  = xs;
            item_next.ang = -mhd_pkg::ZW'(mhd_pkg::QUARTER_UNITS);
        end
        else
        begin
            item_next.cx  = xs;
            item_next.cy  = ys;
            item_next.ang = '0;
        end
    end

    assign front_valid_next = take ? 1'b1 : (push ? 1'b0 : front_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            front_item_reg <= item_next;
        end
    end

    assign push_item = front_item_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mhd_queue.sv =====
// Short FIFO between the front stage and the CORDIC back end.
// Depends on mhd_pkg.
`default_nettype none
module mhd_queue #(
    parameter int DEPTH = mhd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mhd_pkg::item_t   push_item,
    input  wire logic             pop,
    output mhd_pkg::item_t        head_item,
    output mhd_pkg::q_stat_t      q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mhd_pkg::item_t  mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.valid = (count_reg != '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.valid;
    assign head_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mhd_back.sv =====
// Back end: unrolled vectoring CORDIC, alignment add with rounding, wrap to one turn.
// Depends on mhd_pkg.
`default_nettype none
module mhd_back #(
    parameter int CORDIC_STEPS = mhd_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mhd_pkg::item_t     head_item,
    input  wire mhd_pkg::q_stat_t   q_stat,
    output logic                    pop,
    input  wire logic [15:0]        alignment_angle,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      field_x,
    output logic signed [15:0]      field_y,
    output logic signed [15:0]      field_z,
    output logic [15:0]             heading,
    output logic [31:0]             time_out
);

    localparam int STEPS = (CORDIC_STEPS < mhd_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : mhd_pkg::ATAN_ENTRIES;

    logic            advance;
    logic            stage_valid_reg [STEPS];
    mhd_pkg::item_t  stage_item_reg  [STEPS];
    mhd_pkg::item_t  stage_in        [STEPS];
    logic            stage_vin       [STEPS];

    logic                          rnd_valid_reg;
    logic signed [mhd_pkg::HW-1:0] rnd_hund_reg;
    mhd_pkg::item_t                rnd_item_reg;
    logic signed [mhd_pkg::SW-1:0] sum;
    logic signed [mhd_pkg::SW-1:0] sum_rnd;
    logic signed [mhd_pkg::HW-1:0] hund_next;

    logic                          out_valid_reg;
    logic [15:0]                   heading_reg;
    logic [15:0]                   heading_next;
    mhd_pkg::item_t                out_item_reg;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && q_stat.valid;

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            mhd_pkg::item_t        src;
            logic                  vsrc;
            logic signed [mhd_pkg::XW-1:0] dx;
            logic signed [mhd_pkg::XW-1:0] dy;
            logic signed [mhd_pkg::ZW-1:0] da;

            if (k == 0)
            begin : g_first
                assign src  = head_item;
                assign vsrc = q_stat.valid;
            end
            else
            begin : g_next
                assign src  = stage_item_reg[k-1];
                assign vsrc = stage_valid_reg[k-1];
            end

            assign dx = src.cy >>> k;
            assign dy = src.cx >>> k;
            assign da = mhd_pkg::ZW'(mhd_pkg::atan_unit(k));

            always_comb
            begin
                stage_in[k]  = src;
                stage_vin[k] = vsrc;
                if (src.cy >= 0)
                begin
                    stage_in[k].cx  = src.cx + dx;
                    stage_in[k].cy  = src.cy - dy;
                    stage_in[k].ang = src.ang + da;
                end
                else
                begin
                    stage_in[k].cx  = src.cx - dx;
                    stage_in[k].cy  = src.cy + dy;
                    stage_in[k].ang = src.ang - da;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_valid_reg[k] <= 1'b0;
                end
                else if (advance)
                begin
                    stage_valid_reg[k] <= stage_vin[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    stage_item_reg[k] <= stage_in[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        sum = $signed({{(mhd_pkg::SW-mhd_pkg::FRAC_BITS-16){1'b0}}, alignment_angle,
                       {mhd_pkg::FRAC_BITS{1'b0}}});
        if (!stage_item_reg[STEPS-1].zero)
        begin
            sum = sum + mhd_pkg::SW'(stage_item_reg[STEPS-1].ang);
        end
        sum_rnd   = sum + mhd_pkg::SW'(1 << (mhd_pkg::FRAC_BITS - 1));
        hund_next = sum_rnd[mhd_pkg::SW-1:mhd_pkg::FRAC_BITS];
    end

    always_comb
    begin
        priority if (rnd_hund_reg < 0)
        begin
            heading_next = 16'(rnd_hund_reg + mhd_pkg::HW'(mhd_pkg::FULL_TURN));
        end
        else if (rnd_hund_reg >= mhd_pkg::HW'(2 * mhd_pkg::FULL_TURN))
        begin
            heading_next = 16'(rnd_hund_reg - mhd_pkg::HW'(2 * mhd_pkg::FULL_TURN));
        end
        else if (rnd_hund_reg >= mhd_pkg::HW'(mhd_pkg::FULL_TURN))
        begin
            heading_next = 16'(rnd_hund_reg - mhd_pkg::HW'(mhd_pkg::FULL_TURN));
        end
        else
        begin
            heading_next = 16'(rnd_hund_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rnd_valid_reg <= stage_valid_reg[STEPS-1];
            out_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rnd_hund_reg <= hund_next;
            rnd_item_reg <= stage_item_reg[STEPS-1];
            heading_reg  <= heading_next;
            out_item_reg <= rnd_item_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign field_x   = out_item_reg.raw_x;
    assign field_y   = out_item_reg.raw_y;
    assign field_z   = out_item_reg.raw_z;
    assign heading   = heading_reg;
    assign time_out  = out_item_reg.stamp;

endmodule
`default_nettype wire
